[rtl/core/text_console_writer_top_macros.svh]
// Assertion macros for the text console writer.
// Used by text_console_writer_top.sv; depends on a clock and reset in scope.
`ifndef TEXT_CONSOLE_WRITER_TOP_MACROS_SVH
`define TEXT_CONSOLE_WRITER_TOP_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define TCW_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/tcw_pkg.sv]
// Constants and codes for the text console writer.
// No dependencies; used by text_console_writer_top.
`timescale 1ns / 1ps

package tcw_pkg;

   // Screen geometry.
   localparam int NUM_COLUMNS = 80;
   localparam int NUM_ROWS    = 25;
   localparam int CELL_COUNT  = NUM_ROWS * NUM_COLUMNS;

   localparam int ADDR_W = $clog2(CELL_COUNT);
   localparam int ROW_W  = $clog2(NUM_ROWS);
   localparam int COL_W  = $clog2(NUM_COLUMNS);

   // Item field widths.
   localparam int OP_W    = 2;
   localparam int CHAR_W  = 8;
   localparam int ATTR_W  = 8;
   localparam int INDEX_W = 11;
   localparam int CELL_W  = 16;
   localparam int POS_W   = 11;

   localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
   localparam logic [CHAR_W-1:0] CODE_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CODE_LF    = 8'd10;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

endpackage

[rtl/core/text_console_writer_top.sv]
// Text console writer: screen memory, cursor and scroll sequencer.
// Depends on tcw_pkg and text_console_writer_top_macros.svh.
// A put, clear or unused op loads its result into the output register as the item is taken;
// a read first passes through ST_READ. A new item is taken only once the single output
// register is empty. A put that scrolls then holds the input while the screen memory's
// one write port copies one cell a cycle and then blanks the last row. A clear holds it
// while every cell is blanked; after reset the same blanking pass runs before the first
// item is taken.
`timescale 1ns / 1ps
`include "text_console_writer_top_macros.svh"

module text_console_writer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] op, [9:2] ch, [17:10] attr, [28:18] cell_index, [31:29] zero
   input  logic [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] read_data, [26:16] cursor_pos, [27] scrolled, [31:28] zero
   output logic [31:0] rsp_tdata
);

   localparam int ADDR_W = tcw_pkg::ADDR_W;
   localparam int ROW_W  = tcw_pkg::ROW_W;
   localparam int COL_W  = tcw_pkg::COL_W;
   localparam int CELL_W = tcw_pkg::CELL_W;
   localparam int POS_W  = tcw_pkg::POS_W;

   localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(tcw_pkg::CELL_COUNT - 1);
   localparam logic [ADDR_W-1:0] COPY_START  = ADDR_W'(2 * tcw_pkg::NUM_COLUMNS);
   localparam logic [ADDR_W-1:0] LAST_ROW_AT =
      ADDR_W'((tcw_pkg::NUM_ROWS - 1) * tcw_pkg::NUM_COLUMNS);
   localparam logic [ADDR_W-1:0] ROW_STRIDE  = ADDR_W'(tcw_pkg::NUM_COLUMNS);
   localparam logic [ROW_W-1:0]  ROW_FIRST   = ROW_W'(1);
   localparam logic [ROW_W-1:0]  ROW_LAST    = ROW_W'(tcw_pkg::NUM_ROWS - 1);

   // Sequencer states.
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_READ   = 2'd1;
   localparam logic [1:0] ST_SCROLL = 2'd2;
   localparam logic [1:0] ST_FILL   = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [ADDR_W-1:0] scan_ff, scan_in;
   logic              pend_ff;
   logic [ADDR_W-1:0] pend_addr_ff;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic              oob_ff, oob_in;
   logic [CELL_W-1:0] rd_data_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0] rsp_data_ff, rsp_data_in;
   logic [POS_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic              rsp_scr_ff, rsp_scr_in;

   // Screen memory.
   logic [CELL_W-1:0] screen_mem [tcw_pkg::CELL_COUNT];
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [CELL_W-1:0] mem_wdata;
   logic [ADDR_W-1:0] mem_raddr;

   // Input item fields.
   logic [tcw_pkg::OP_W-1:0]    req_op;
   logic [tcw_pkg::CHAR_W-1:0]  req_ch;
   logic [tcw_pkg::ATTR_W-1:0]  req_attr;
   logic [tcw_pkg::INDEX_W-1:0] req_index;
   logic                        accept;

   // Put decoding.
   logic              is_cr, is_lf, put_write, advance_row, row_wrap, col_wrap, put_scroll;
   logic [ROW_W:0]    row_inc;
   logic [COL_W:0]    col_inc;
   logic [ROW_W-1:0]  put_row;
   logic [COL_W-1:0]  put_col;
   logic [ADDR_W-1:0] cur_addr;
   logic [POS_W-1:0]  next_pos;

   assign req_op    = req_tdata[1:0];
   assign req_ch    = req_tdata[9:2];
   assign req_attr  = req_tdata[17:10];
   assign req_index = req_tdata[28:18];

   assign req_tready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign accept     = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_scr_ff, rsp_pos_ff, rsp_data_ff};

   // Cursor movement for a put.
   always_comb begin
      is_cr       = (req_ch == tcw_pkg::CODE_CR);
      is_lf       = (req_ch == tcw_pkg::CODE_LF);
      put_write   = !is_cr && !is_lf;
      row_inc     = {1'b0, row_ff} + (ROW_W + 1)'(1);
      col_inc     = {1'b0, col_ff} + (COL_W + 1)'(1);
      row_wrap    = (row_inc >= (ROW_W + 1)'(tcw_pkg::NUM_ROWS));
      col_wrap    = (col_inc >= (COL_W + 1)'(tcw_pkg::NUM_COLUMNS));
      advance_row = is_lf || (put_write && col_wrap);
      put_scroll  = advance_row && row_wrap;
      put_col     = (put_write && !col_wrap) ? col_inc[COL_W-1:0] : '0;
      if (!advance_row) begin
         put_row = row_ff;
      end else if (row_wrap) begin
         put_row = ROW_LAST;
      end else begin
         put_row = row_inc[ROW_W-1:0];
      end
      cur_addr = ADDR_W'(int'(row_ff) * tcw_pkg::NUM_COLUMNS + int'(col_ff));
   end

   // Sequencer and cursor next values.
   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      oob_in       = oob_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_scr_in   = rsp_scr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_scr_in   = 1'b0;
               unique case (req_op)
                  tcw_pkg::OP_PUT: begin
                     row_in     = put_row;
                     col_in     = put_col;
                     rsp_scr_in = put_scroll;
                     if (put_scroll) begin
                        state_in = ST_SCROLL;
                        scan_in  = COPY_START;
                     end
                  end
                  tcw_pkg::OP_READ: begin
                     rsp_valid_in = 1'b0;
                     state_in     = ST_READ;
                     oob_in = (int'(req_index) >= tcw_pkg::CELL_COUNT);
                  end
                  tcw_pkg::OP_CLEAR: begin
                     row_in   = ROW_FIRST;
                     col_in   = '0;
                     state_in = ST_FILL;
                     scan_in  = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = oob_ff ? '0 : rd_data_ff;
            rsp_scr_in   = 1'b0;
            state_in     = ST_IDLE;
         end
         ST_SCROLL: begin
            if (scan_ff == LAST_ADDR) begin
               state_in = ST_FILL;
               scan_in  = LAST_ROW_AT;
            end else begin
               scan_in = scan_ff + ADDR_W'(1);
            end
         end
         ST_FILL: begin
            // The last copy write of a scroll takes the write port first.
            if (!pend_ff) begin
               if (scan_ff == LAST_ADDR) begin
                  state_in = ST_IDLE;
               end else begin
                  scan_in = scan_ff + ADDR_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      next_pos = POS_W'(int'(row_in) * tcw_pkg::NUM_COLUMNS + int'(col_in));
      if (accept) begin
         rsp_pos_in = next_pos;
      end
   end

   // Write port: scroll copies first, then blanking, then put characters.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cur_addr;
      mem_wdata = {req_attr, req_ch};
      if (pend_ff) begin
         mem_we    = 1'b1;
         mem_waddr = pend_addr_ff;
         mem_wdata = rd_data_ff;
      end else if (state_ff == ST_FILL) begin
         mem_we    = 1'b1;
         mem_waddr = scan_ff;
         mem_wdata = tcw_pkg::BLANK_CELL;
      end else if (accept && req_op == tcw_pkg::OP_PUT && put_write) begin
         mem_we = 1'b1;
      end
      mem_raddr = (state_ff == ST_SCROLL) ? scan_ff : ADDR_W'(req_index);
   end

   // Screen memory with a registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= screen_mem[mem_raddr];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         scan_ff      <= '0;
         pend_ff      <= 1'b0;
         row_ff       <= ROW_FIRST;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         pend_ff      <= (state_ff == ST_SCROLL);
         row_ff       <= row_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pend_addr_ff <= scan_ff - ROW_STRIDE;
      oob_ff       <= oob_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_scr_ff   <= rsp_scr_in;
   end

   // Checks on the sequencer.
   `TCW_ASSERT_NOW(a_pend_in_sweep, pend_ff, state_ff == ST_FILL || state_ff == ST_SCROLL, "copy write outside a scroll")
   `TCW_ASSERT_NOW(a_row_range, state_ff == ST_IDLE, row_ff != '0 && row_ff <= ROW_LAST, "cursor row out of range")
   `TCW_ASSERT_NOW(a_scan_range, state_ff == ST_FILL || state_ff == ST_SCROLL, scan_ff <= LAST_ADDR, "scan address out of range")
   `TCW_ASSERT_NEXT(a_scroll_result, accept && req_op == tcw_pkg::OP_PUT && put_scroll, rsp_valid_ff && rsp_scr_ff && state_ff == ST_SCROLL, "scroll not reported")

endmodule
